// ===== rtl/core/iee_pkg.sv =====
`timescale 1ns / 1ps

package iee_pkg;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned ENERGY_W  = 32;

  localparam logic [COUNT_W-1:0] SPIN_COUNT_RESET = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE_COUPLING = 2'd0,
    ACT_WRITE_SPIN     = 2'd1,
    ACT_FLIP_DELTA     = 2'd2,
    ACT_TOTAL_ENERGY   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR2,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    action_t                    action;
    logic [INDEX_W-1:0]         first_index;
    logic [INDEX_W-1:0]         second_index;
    logic signed [VALUE_W-1:0]  coupling_value;
    logic                       spin_up;
  } in_req_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic                       is_total;
  } out_req_t;

endpackage

// ===== rtl/core/ising_energy_evaluator.sv =====
`timescale 1ns / 1ps
// Ising problem store and energy evaluator.
// Input channel (in_valid / in_stall / in_data): one request per item. Coupling
// and field writes, spin writes, flip delta queries and total energy queries.
// Writes give no result; each query gives one result on the output channel
// (out_valid / out_stall / out_data), is_total telling which kind it is.
// cfg_we / cfg_wdata set the number of spins in use; write it only while idle.
// Operation, with n the spins in use:
//   spin write, field write: written as the request is taken; coupling write:
//   mirrored in ST_WR2 (both halves of the symmetric pair share the single write port).
//   flip delta: walks the row of n entries, one coupling row entry read per cycle.
//   total energy: walks the upper half of the matrix including the diagonal,
//   one memory read per cycle.
//   A query on an index out of use, or a total with n = 0, skips the walk.
// One request is in flight at a time; a new one is taken while a finished
// result still waits in the output register. If the receiver stalls, the
// result is held and a following query waits in its last cycle.
// After reset the memories are swept: couplings and fields to zero, spins up;
// in_stall stays high until every coupling address has been written.
module ising_energy_evaluator import iee_pkg::*; #(
  parameter int MAX_SPINS     = 64,
  parameter int COUPLING_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_req_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_req_t            out_data,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata
);

  localparam int IDX_W   = $clog2(MAX_SPINS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int AW      = 2 * IDX_W;
  localparam int CB      = COUPLING_BITS;
  localparam int ACC_W   = COUPLING_BITS + 2 * IDX_W + 2;
  localparam int FIN_W   = ACC_W + 2;
  localparam int SAT_W   = (FIN_W > ENERGY_W) ? FIN_W : ENERGY_W + 1;

  localparam logic signed [SAT_W-1:0] E_MAX = SAT_W'(32'sh7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] E_MIN = SAT_W'(32'sh8000_0000);

  // memories
  logic signed [CB-1:0] coup_mem  [(1 << AW)];
  logic signed [CB-1:0] field_mem [(1 << IDX_W)];
  logic                 spin_mem  [(1 << IDX_W)];

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]   spin_count_r;
  logic [AW-1:0]        clr_cnt_r;
  logic [IDX_W-1:0]     i_r, j_r;
  logic [CNT_W-1:0]     n_r;
  logic                 total_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                 sa_r;
  logic                 rd_vld_r;
  logic                 rd_diag_r;
  logic signed [CB-1:0] coup_rd_r;
  logic signed [CB-1:0] field_rd_r;
  logic                 sp_a_rd_r;
  logic                 sp_b_rd_r;
  logic                 out_valid_r;
  out_req_t             out_data_r;

  // decoded request
  logic [CNT_W-1:0]     n_eff;
  logic [IDX_W-1:0]     a_idx, b_idx;
  logic                 a_ok, b_ok;
  logic                 in_acc;
  logic signed [CB-1:0] wr_value;

  // walk control
  logic                 j_last, i_last, walk_last;
  logic                 out_free;

  // memory controls
  logic                 cp_we;
  logic [AW-1:0]        cp_waddr;
  logic signed [CB-1:0] cp_wdata;
  logic                 fd_we;
  logic [IDX_W-1:0]     fd_waddr;
  logic signed [CB-1:0] fd_wdata;
  logic                 sp_we;
  logic [IDX_W-1:0]     sp_waddr;
  logic                 sp_wdata;
  logic                 clr_low;

  // datapath
  logic                    term_pos;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [FIN_W-1:0] fin;
  logic signed [FIN_W-1:0] fin_dbl;
  logic signed [SAT_W-1:0] fin_ext;
  logic signed [ENERGY_W-1:0] energy_sat;

  assign n_eff = (int'(spin_count_r) < MAX_SPINS) ? CNT_W'(spin_count_r)
                                                  : CNT_W'(MAX_SPINS);
  assign a_ok     = int'(in_data.first_index)  < int'(n_eff);
  assign b_ok     = int'(in_data.second_index) < int'(n_eff);
  assign a_idx    = IDX_W'(in_data.first_index);
  assign b_idx    = IDX_W'(in_data.second_index);
  assign wr_value = CB'(in_data.coupling_value);
  assign in_acc   = in_valid && !in_stall;

  assign j_last    = ({1'b0, j_r} == (n_r - CNT_W'(1)));
  assign i_last    = ({1'b0, i_r} == (n_r - CNT_W'(1)));
  assign walk_last = total_r ? (j_last && i_last) : j_last;
  assign out_free  = !out_valid_r || !out_stall;
  assign clr_low   = (clr_cnt_r[AW-1:IDX_W] == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.action)
            ACT_WRITE_COUPLING: begin
              if (a_ok && b_ok && (a_idx != b_idx)) state_nxt = ST_WR2;
            end
            ACT_WRITE_SPIN:     state_nxt = ST_IDLE;
            ACT_FLIP_DELTA:     state_nxt = a_ok ? ST_WALK : ST_FINISH;
            ACT_TOTAL_ENERGY:   state_nxt = (n_eff != '0) ? ST_WALK : ST_FINISH;
            default:            state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WR2:   state_nxt = ST_IDLE;
      ST_WALK: begin
        if (walk_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and memory writes
  always_comb begin
    in_stall = 1'b1;
    cp_we    = 1'b0;
    cp_waddr = {i_r, j_r};
    cp_wdata = wr_value;
    fd_we    = 1'b0;
    fd_waddr = a_idx;
    fd_wdata = wr_value;
    sp_we    = 1'b0;
    sp_waddr = a_idx;
    sp_wdata = in_data.spin_up;
    case (state_r)
      ST_CLEAR: begin
        cp_we    = 1'b1;
        cp_waddr = clr_cnt_r;
        cp_wdata = '0;
        fd_we    = clr_low;
        fd_waddr = clr_cnt_r[IDX_W-1:0];
        fd_wdata = '0;
        sp_we    = clr_low;
        sp_waddr = clr_cnt_r[IDX_W-1:0];
        sp_wdata = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc && (in_data.action == ACT_WRITE_COUPLING) && a_ok && b_ok) begin
          if (a_idx == b_idx) begin
            fd_we = 1'b1;
          end else begin
            cp_we    = 1'b1;
            cp_waddr = {a_idx, b_idx};
          end
        end
        if (in_acc && (in_data.action == ACT_WRITE_SPIN) && a_ok) sp_we = 1'b1;
      end
      ST_WR2: begin
        // mirror half of the symmetric pair
        cp_we    = 1'b1;
        cp_waddr = {j_r, i_r};
        cp_wdata = acc_r[CB-1:0];
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // memories: one write port each, registered reads
  always_ff @(posedge clk) begin
    if (cp_we) coup_mem[cp_waddr] <= cp_wdata;
    coup_rd_r <= coup_mem[{i_r, j_r}];
  end

  always_ff @(posedge clk) begin
    if (fd_we) field_mem[fd_waddr] <= fd_wdata;
    field_rd_r <= field_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (sp_we) spin_mem[sp_waddr] <= sp_wdata;
    sp_a_rd_r <= spin_mem[i_r];
    sp_b_rd_r <= spin_mem[j_r];
  end

  // accumulate one term per read; a diagonal cell brings the local field
  always_comb begin
    if (rd_diag_r) begin
      term_pos = total_r ? sp_a_rd_r : 1'b1;
      term     = ACC_W'(field_rd_r);
    end else begin
      term_pos = total_r ? ~(sp_a_rd_r ^ sp_b_rd_r) : sp_b_rd_r;
      term     = ACC_W'(coup_rd_r);
    end
    acc_nxt = term_pos ? (acc_r + term) : (acc_r - term);
  end

  always_comb begin
    fin     = FIN_W'(acc_r);
    fin_dbl = fin <<< 1;
    if (!total_r) fin = sa_r ? -fin_dbl : fin_dbl;
    fin_ext = SAT_W'(fin);
    if (fin_ext > E_MAX) begin
      energy_sat = ENERGY_W'(E_MAX);
    end else if (fin_ext < E_MIN) begin
      energy_sat = ENERGY_W'(E_MIN);
    end else begin
      energy_sat = ENERGY_W'(fin_ext);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      spin_count_r <= SPIN_COUNT_RESET;
      clr_cnt_r    <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_WALK);
      if (cfg_we) spin_count_r <= cfg_wdata;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_diag_r <= (i_r == j_r);
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          total_r <= (in_data.action == ACT_TOTAL_ENERGY);
          n_r     <= n_eff;
          i_r     <= (in_data.action == ACT_TOTAL_ENERGY) ? '0 : a_idx;
          j_r     <= (in_data.action == ACT_WRITE_COUPLING) ? b_idx : '0;
          // the accumulator carries the value for the mirrored coupling write
          acc_r   <= (in_data.action == ACT_WRITE_COUPLING) ? ACC_W'(wr_value) : '0;
        end
      end
      ST_WALK: begin
        if (rd_vld_r) begin
          acc_r <= acc_nxt;
          sa_r  <= sp_a_rd_r;
        end
        if (j_last) begin
          // next row starts on its diagonal
          i_r <= i_r + IDX_W'(1);
          j_r <= i_r + IDX_W'(1);
        end else begin
          j_r <= j_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (rd_vld_r) begin
          acc_r <= acc_nxt;
          sa_r  <= sp_a_rd_r;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_data_r.energy   <= energy_sat;
          out_data_r.is_total <= total_r;
        end
      end
      default: begin
        sa_r <= sa_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
